/* hw/rtl/gray_contrast_stretch_core_assert.svh */
// ----------------------------------------------------------------------------
// Assertion macros for the contrast stretch core
// Clocked on clk, disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GRAY_CONTRAST_STRETCH_CORE_ASSERT_SVH
`define GRAY_CONTRAST_STRETCH_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define GCS_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define GCS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* hw/rtl/gcs_pkg.sv */
// ----------------------------------------------------------------------------
// gcs_pkg
// Widths, mode codes and the divider cell payload for the contrast stretch core.
// ----------------------------------------------------------------------------
package gcs_pkg;

  localparam int unsigned PIX_W = 8;
  localparam int unsigned QUO_W = 8;
  // 510*(p-min)+d stays below 2^17
  localparam int unsigned NUM_W = 17;
  // 2*d
  localparam int unsigned DEN_W = PIX_W + 1;

  localparam logic [PIX_W-1:0] FULL_SCALE = 8'd255;
  localparam logic [PIX_W-1:0] LOW_RESET  = 8'd255;
  localparam logic [PIX_W-1:0] HIGH_RESET = 8'd0;
  localparam logic [NUM_W-1:0] TWO_FULL   = 17'd510;

  localparam logic MODE_GATHER = 1'b0;
  localparam logic MODE_APPLY  = 1'b1;

  typedef struct packed {
    logic             valid;
    logic             force_en;    // result fixed, quotient ignored
    logic             force_full;  // fixed result is full scale, else zero
    logic [NUM_W-1:0] rem;
    logic [DEN_W-1:0] den;
    logic [QUO_W-1:0] quo;
  } gcs_div_t;

endpackage

/* hw/rtl/gcs_prep.sv */
// ----------------------------------------------------------------------------
// gcs_prep
// Holds running min/max, folds gather beats into it and turns apply beats
// into a numerator/denominator pair for the divider chain.
// ----------------------------------------------------------------------------
`include "gray_contrast_stretch_core_assert.svh"

module gcs_prep (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    advance,
  input  logic                    accept,
  input  logic [gcs_pkg::PIX_W-1:0] pixel,
  input  logic                    mode,
  input  logic                    first,
  output gcs_pkg::gcs_div_t       div_out
);
  import gcs_pkg::*;

  logic [PIX_W-1:0] low_r, low_nxt;
  logic [PIX_W-1:0] high_r, high_nxt;
  gcs_div_t         div_r, div_nxt;
  logic [PIX_W-1:0] diff;
  logic [PIX_W-1:0] span;
  logic             gather_beat;
  logic             flat_out;

  assign gather_beat = accept && (mode == MODE_GATHER);

  always_comb begin
    low_nxt  = low_r;
    high_nxt = high_r;
    if (gather_beat) begin
      if (first) begin
        low_nxt  = pixel;
        high_nxt = pixel;
      end else begin
        if (pixel < low_r) low_nxt = pixel;
        if (pixel > high_r) high_nxt = pixel;
      end
    end
  end

  assign diff = pixel - low_r;
  assign span = high_r - low_r;

  always_comb begin
    div_nxt.valid      = accept && (mode == MODE_APPLY);
    div_nxt.force_en   = 1'b0;
    div_nxt.force_full = 1'b0;
    div_nxt.rem        = NUM_W'(diff) * TWO_FULL + NUM_W'(span);
    div_nxt.den        = {span, 1'b0};
    div_nxt.quo        = '0;
    // empty or flat range, and pixels at or below min, give zero
    priority if (high_r <= low_r) begin
      div_nxt.force_en = 1'b1;
    end else if (pixel <= low_r) begin
      div_nxt.force_en = 1'b1;
    end else if (pixel >= high_r) begin
      div_nxt.force_en   = 1'b1;
      div_nxt.force_full = 1'b1;
    end else begin
      // in range: quotient comes from the divider chain
      div_nxt.force_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_r  <= LOW_RESET;
      high_r <= HIGH_RESET;
    end else begin
      low_r  <= low_nxt;
      high_r <= high_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r.valid <= 1'b0;
    end else if (advance) begin
      div_r <= div_nxt;
    end
  end

  assign div_out  = div_r;
  assign flat_out = div_r.valid && (div_r.den == '0);

  `GCS_ASSERT_NEXT(a_range_order, gather_beat, low_r <= high_r, "min above max after gather")
  `GCS_ASSERT_NEXT(a_first_low, gather_beat && first, low_r == $past(pixel), "min not restarted")
  `GCS_ASSERT_NEXT(a_first_high, gather_beat && first, high_r == $past(pixel), "max not restarted")
  `GCS_ASSERT_SAME(a_flat_forced, flat_out, div_r.force_en && !div_r.force_full, "flat not zero")

endmodule

/* hw/rtl/gcs_cell.sv */
// ----------------------------------------------------------------------------
// gcs_cell
// One restoring-division cell: resolves quotient bit BIT and passes the
// partial remainder on to the next cell.
// ----------------------------------------------------------------------------
module gcs_cell #(
  parameter int unsigned BIT = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              advance,
  input  gcs_pkg::gcs_div_t div_in,
  output gcs_pkg::gcs_div_t div_out
);
  import gcs_pkg::*;

  gcs_div_t         div_r, div_nxt;
  logic [NUM_W-1:0] trial;

  assign trial = NUM_W'(div_in.den) << BIT;

  always_comb begin
    div_nxt = div_in;
    if (div_in.rem >= trial) begin
      div_nxt.rem      = div_in.rem - trial;
      div_nxt.quo[BIT] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_r.valid <= 1'b0;
    end else if (advance) begin
      div_r <= div_nxt;
    end
  end

  assign div_out = div_r;

endmodule

/* hw/rtl/gray_contrast_stretch_core.sv */
// Stages: an apply beat passes the prep stage, 8 divider cells and the
// output register; gather beats give no result.
// Throughput: one pixel per cycle; the whole chain stalls while a result
// waits in the output register, set by the 8-cell restoring divider pipeline.
// Reset: synchronous active-low; min resets to 255, max to 0, chain empties.
// ----------------------------------------------------------------------------
// gray_contrast_stretch_core
// Two-pass min/max contrast stretching of 8-bit gray pixels.
// ----------------------------------------------------------------------------
`include "gray_contrast_stretch_core_assert.svh"

module gray_contrast_stretch_core (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  logic [gcs_pkg::PIX_W-1:0] in_pixel,
  input  logic                      in_mode,
  input  logic                      in_first,
  output logic                      out_valid,
  input  logic                      out_ready,
  output logic [gcs_pkg::PIX_W-1:0] out_stretched
);
  import gcs_pkg::*;

  gcs_div_t         chain [QUO_W+1];
  logic             advance;
  logic             accept;
  logic             out_valid_r;
  logic [PIX_W-1:0] out_stretched_r, out_stretched_nxt;

  assign advance  = !out_valid_r || out_ready;
  assign in_ready = advance;
  assign accept   = in_valid && in_ready;

  gcs_prep u_prep (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .accept  (accept),
    .pixel   (in_pixel),
    .mode    (in_mode),
    .first   (in_first),
    .div_out (chain[0])
  );

  // quotient bits resolved MSB first
  for (genvar i = 0; i < QUO_W; i++) begin : g_cell
    gcs_cell #(
      .BIT (QUO_W - 1 - i)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .advance (advance),
      .div_in  (chain[i]),
      .div_out (chain[i+1])
    );
  end

  always_comb begin
    unique case ({chain[QUO_W].force_en, chain[QUO_W].force_full})
      2'b10:   out_stretched_nxt = '0;
      2'b11:   out_stretched_nxt = FULL_SCALE;
      default: out_stretched_nxt = chain[QUO_W].quo;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= chain[QUO_W].valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_stretched_r <= out_stretched_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_stretched = out_stretched_r;

  `GCS_ASSERT_SAME(a_rem_bound, chain[QUO_W].valid && !chain[QUO_W].force_en, chain[QUO_W].rem < NUM_W'(chain[QUO_W].den), "divider remainder not below divisor")
  `GCS_ASSERT_NEXT(a_out_follows, advance, out_valid_r == $past(chain[QUO_W].valid), "output valid lost chain item")
  `GCS_ASSERT_NEXT(a_stall_keeps, chain[0].valid && !advance, chain[0].valid, "stalled prep item dropped")

endmodule

/* test/gray_contrast_stretch_checker.sv */
// ----------------------------------------------------------------------------
// gray_contrast_stretch_checker
// Watches the pixel and result channels of the contrast stretch core. It
// tracks the gathered min/max range, predicts each stretched level and
// compares the results in order.
// ----------------------------------------------------------------------------
module gray_contrast_stretch_checker (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  input  logic                      in_ready,
  input  logic [gcs_pkg::PIX_W-1:0] in_pixel,
  input  logic                      in_mode,
  input  logic                      in_first,
  input  logic                      out_valid,
  input  logic                      out_ready,
  input  logic [gcs_pkg::PIX_W-1:0] out_stretched,
  output int                        mismatch_count,
  output int                        levels_owed
);
  timeunit 1ns;
  timeprecision 1ps;

  import gcs_pkg::*;

  logic [PIX_W-1:0] range_low  = LOW_RESET;
  logic [PIX_W-1:0] range_high = HIGH_RESET;
  logic [PIX_W-1:0] level_q[$];
  logic [PIX_W-1:0] want_level;
  int               errors = 0;

  // round(255*(p-lo)/(hi-lo)), halves up; empty or flat range gives zero
  function automatic logic [PIX_W-1:0] stretch_level(input logic [PIX_W-1:0] pix,
                                                     input logic [PIX_W-1:0] lo,
                                                     input logic [PIX_W-1:0] hi);
    int unsigned full;
    int unsigned span;
    int unsigned level;
    full = 32'(FULL_SCALE);
    if (hi <= lo) return '0;
    if (pix <= lo) return '0;
    if (pix >= hi) return FULL_SCALE;
    span  = int'(hi) - int'(lo);
    level = (2 * full * (int'(pix) - int'(lo)) + span) / (2 * span);
    if (level > full) level = full;
    return level[PIX_W-1:0];
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      range_low  = LOW_RESET;
      range_high = HIGH_RESET;
      level_q.delete();
    end else begin
      if (in_valid && in_ready) begin
        if (in_mode == MODE_GATHER) begin
          if (in_first) begin
            range_low  = in_pixel;
            range_high = in_pixel;
          end else begin
            if (in_pixel < range_low)  range_low  = in_pixel;
            if (in_pixel > range_high) range_high = in_pixel;
          end
        end else begin
          level_q.push_back(stretch_level(in_pixel, range_low, range_high));
        end
      end
      if (out_valid && out_ready) begin
        if (level_q.size() == 0) begin
          $display("%0t: unexpected result beat, expected none, actual stretched=%0d",
                   $time, out_stretched);
          errors++;
        end else begin
          want_level = level_q.pop_front();
          if (out_stretched !== want_level) begin
            $display("%0t: stretched mismatch, expected %0d, actual %0d",
                     $time, want_level, out_stretched);
            errors++;
          end
        end
      end
    end
    mismatch_count <= errors;
    levels_owed    <= level_q.size();
  end

endmodule

/* test/gray_contrast_stretch_core_tb.sv */
// ----------------------------------------------------------------------------
// gray_contrast_stretch_core_tb
// Drives gather/apply pixel frames into the contrast stretch core with random
// sender idling and receiver stalls; the checker predicts and compares.
// ----------------------------------------------------------------------------
module gray_contrast_stretch_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import gcs_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int PHASE_ITEMS  = 470;
  localparam int DRAIN_CYCLES = 16;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             in_valid = 1'b0;
  logic             in_ready;
  logic [PIX_W-1:0] in_pixel = '0;
  logic             in_mode = MODE_GATHER;
  logic             in_first = 1'b0;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [PIX_W-1:0] out_stretched;

  int mismatch_count;
  int levels_owed;
  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int pixels_sent = 0;
  int cycle_count = 0;

  always #5 clk = ~clk;

  gray_contrast_stretch_core u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_pixel     (in_pixel),
    .in_mode      (in_mode),
    .in_first     (in_first),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_stretched(out_stretched)
  );

  gray_contrast_stretch_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_pixel      (in_pixel),
    .in_mode       (in_mode),
    .in_first      (in_first),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_stretched (out_stretched),
    .mismatch_count(mismatch_count),
    .levels_owed   (levels_owed)
  );

  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_stall_pct);
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("gray_contrast_stretch_core verification failed");
    $finish;
  end

  // one pixel beat; returns at the edge where it was taken
  task automatic send_pixel(input logic [PIX_W-1:0] pix, input logic mode,
                            input logic first_flag);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_pixel <= pix;
    in_mode  <= mode;
    in_first <= first_flag;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pixels_sent++;
  endtask

  // gather pass over a random window, then an apply pass
  task automatic send_frame();
    int lo;
    int hi;
    int n_gather;
    int n_apply;
    lo = $urandom_range(255);
    if ($urandom_range(3) == 0) hi = lo + $urandom_range(3);
    else hi = $urandom_range(255, lo);
    if (hi > 255) hi = 255;
    n_gather = $urandom_range(12, 1);
    n_apply  = $urandom_range(16, 1);
    send_pixel(PIX_W'(lo), MODE_GATHER, 1'b1);
    send_pixel(PIX_W'(hi), MODE_GATHER, 1'b0);
    for (int i = 0; i < n_gather; i++)
      send_pixel(PIX_W'($urandom_range(hi, lo)), MODE_GATHER, 1'b0);
    for (int i = 0; i < n_apply; i++) begin
      if ($urandom_range(2) == 0) begin
        send_pixel(PIX_W'($urandom_range(255)), MODE_APPLY, 1'($urandom_range(1)));
      end else begin
        send_pixel(PIX_W'($urandom_range(hi, lo)), MODE_APPLY, 1'($urandom_range(1)));
      end
    end
  endtask

  // stray beats: mixed modes and flags, no frame structure
  task automatic send_noise();
    int n;
    n = $urandom_range(6, 1);
    for (int i = 0; i < n; i++)
      send_pixel(PIX_W'($urandom_range(255)), 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // nothing gathered yet: empty range, first flag ignored on apply
    send_pixel(8'd128, MODE_APPLY, 1'b0);
    send_pixel(8'd0,   MODE_APPLY, 1'b1);
    send_pixel(8'd255, MODE_APPLY, 1'b1);
    // extend from reset without a first flag: flat at 255, then full range
    send_pixel(8'd255, MODE_GATHER, 1'b0);
    send_pixel(8'd255, MODE_APPLY,  1'b0);
    send_pixel(8'd0,   MODE_GATHER, 1'b0);
    send_pixel(8'd0,   MODE_APPLY,  1'b0);
    send_pixel(8'd255, MODE_APPLY,  1'b0);
    send_pixel(8'd128, MODE_APPLY,  1'b0);
    send_pixel(8'd1,   MODE_APPLY,  1'b0);
    send_pixel(8'd254, MODE_APPLY,  1'b0);
    // flat range after a restart
    send_pixel(8'd100, MODE_GATHER, 1'b1);
    send_pixel(8'd100, MODE_APPLY,  1'b0);
    send_pixel(8'd101, MODE_APPLY,  1'b0);
    // 100..110: half rounds up at 105, saturation both sides
    send_pixel(8'd110, MODE_GATHER, 1'b0);
    send_pixel(8'd105, MODE_APPLY,  1'b0);
    send_pixel(8'd99,  MODE_APPLY,  1'b0);
    send_pixel(8'd111, MODE_APPLY,  1'b0);
    send_pixel(8'd100, MODE_APPLY,  1'b1);
    // unit span
    send_pixel(8'd7,   MODE_GATHER, 1'b1);
    send_pixel(8'd8,   MODE_GATHER, 1'b0);
    send_pixel(8'd7,   MODE_APPLY,  1'b0);
    send_pixel(8'd8,   MODE_APPLY,  1'b0);

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 79; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 79; end
        default: begin send_idle_pct = 29; recv_stall_pct = 29; end
      endcase
      pixels_sent = 0;
      while (pixels_sent < PHASE_ITEMS) begin
        if ($urandom_range(9) < 8) send_frame();
        else send_noise();
      end
    end

    in_valid <= 1'b0;
    @(posedge clk);
    while (levels_owed != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("gray_contrast_stretch_core verification clean");
    end else begin
      $display("gray_contrast_stretch_core verification failed");
    end
    $finish;
  end

endmodule
